### rtl/core/vlr_pkg.sv
// Package for the voxel line rasterizer: beat types, command codes,
// controller/datapath command and status structs and store sizing constants.
// No dependencies.
package vlr_pkg;

	localparam int CUBE_SIZE_DEF = 8;
	localparam int STORE_DEPTH   = 64;
	localparam int IDX_W         = 6;
	localparam int COORD_W       = 8;
	localparam int COUNT_W       = 9;
	localparam int ERR_W         = 12;

	localparam logic [1:0] CMD_DRAW  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] z_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic [COORD_W-1:0] z_end;
		logic [IDX_W-1:0]   read_index;
	} cmd_beat_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic [COUNT_W-1:0] plotted_count;
	} rsp_beat_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic advance;
		logic rd_point;
		logic rd_index;
		logic wr;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
		logic at_end;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/core/vlr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vlr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/vlr_ctrl.sv
// Controller state machine of the voxel line rasterizer.
// Depends on vlr_pkg; drives the datapath through dp_cmd_t, watches dp_stat_t.
module vlr_ctrl
	import vlr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic [1:0] command,
	output logic       cmd_stall,
	input  dp_stat_t   stat,
	output dp_cmd_t    dcmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STEP  = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_RDREQ = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		dcmd      = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					dcmd.load = 1'b1;
					case (command)
						CMD_DRAW: state_nxt = S_STEP;
						CMD_READ: state_nxt = S_RDREQ;
						CMD_CLEAR: begin
							dcmd.clear = 1'b1;
							state_nxt  = S_DONE;
						end
						default: state_nxt = S_DONE;
					endcase
				end
			end
			S_STEP: begin
				if (stat.in_range) begin
					dcmd.rd_point = 1'b1;
					state_nxt     = S_WRITE;
				end else if (stat.at_end) begin
					state_nxt = S_DONE;
				end else begin
					dcmd.advance = 1'b1;
				end
			end
			S_WRITE: begin
				dcmd.wr = 1'b1;
				if (stat.at_end) begin
					state_nxt = S_DONE;
				end else begin
					dcmd.advance = 1'b1;
					state_nxt    = S_STEP;
				end
			end
			S_RDREQ: begin
				dcmd.rd_index = 1'b1;
				state_nxt     = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					dcmd.finish = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((dcmd.rd_point || dcmd.rd_index) && dcmd.wr))
		else $error("store read and write issued together");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.finish |=> (state_q == S_IDLE))
		else $error("controller not idle after finish");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.wr |-> $past(dcmd.rd_point))
		else $error("voxel write without preceding read");

endmodule

### rtl/core/vlr_datapath.sv
// Datapath of the voxel line rasterizer: line stepper, Bresenham error terms,
// frame store with per-byte valid bits, and the result register.
// Depends on vlr_pkg and vlr_ram.
module vlr_datapath
	import vlr_pkg::*;
#(
	parameter int CUBE_SIZE = CUBE_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_beat_t cmd_beat,
	input  dp_cmd_t   dcmd,
	output dp_stat_t  stat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat
);

	logic [1:0]               op_q;
	logic [IDX_W-1:0]         rd_index_q;
	logic [COORD_W-1:0]       p_q   [3];
	logic [COORD_W-1:0]       fin_q [3];
	logic [COORD_W:0]         a_q   [3];
	logic signed [1:0]        s_q   [3];
	logic signed [ERR_W-1:0]  err_q [3];
	logic [1:0]               dom_q;
	logic [COUNT_W-1:0]       count_q;
	logic [STORE_DEPTH-1:0]   valid_q;
	logic                     out_valid_q;
	rsp_beat_t                out_q;

	logic [COORD_W-1:0]       beg_l [3];
	logic [COORD_W-1:0]       fin_l [3];
	logic signed [COORD_W:0]  d_l   [3];
	logic [COORD_W-1:0]       ad_l  [3];
	logic [COORD_W:0]         a_l   [3];
	logic signed [1:0]        s_l   [3];
	logic signed [ERR_W-1:0]  err_l [3];
	logic [1:0]               dom_l;

	logic [COORD_W-1:0]       p_n   [3];
	logic signed [ERR_W-1:0]  err_n [3];

	logic [IDX_W-1:0]         pt_idx;
	logic [IDX_W-1:0]         raddr;
	logic [7:0]               rdata;
	logic [7:0]               wdata;

	always_comb begin
		beg_l[0] = cmd_beat.x_start;
		beg_l[1] = cmd_beat.y_start;
		beg_l[2] = cmd_beat.z_start;
		fin_l[0] = cmd_beat.x_end;
		fin_l[1] = cmd_beat.y_end;
		fin_l[2] = cmd_beat.z_end;
		for (int k = 0; k < 3; k++) begin
			d_l[k]  = $signed({1'b0, fin_l[k]}) - $signed({1'b0, beg_l[k]});
			ad_l[k] = d_l[k][COORD_W] ? COORD_W'(-d_l[k]) : d_l[k][COORD_W-1:0];
			a_l[k]  = {ad_l[k], 1'b0};
			s_l[k]  = d_l[k][COORD_W] ? -2'sd1 : ((d_l[k] != '0) ? 2'sd1 : 2'sd0);
		end
		if (a_l[0] >= a_l[1] && a_l[0] >= a_l[2]) begin
			dom_l = AX_X;
		end else if (a_l[1] >= a_l[2]) begin
			dom_l = AX_Y;
		end else begin
			dom_l = AX_Z;
		end
		for (int k = 0; k < 3; k++) begin
			err_l[k] = $signed(ERR_W'(a_l[k])) - $signed(ERR_W'(ad_l[dom_l]));
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_n[k]   = p_q[k];
			err_n[k] = err_q[k];
			if (2'(k) == dom_q) begin
				p_n[k] = p_q[k] + COORD_W'(s_q[k]);
			end else begin
				if (err_q[k] >= 0) begin
					p_n[k]   = p_q[k] + COORD_W'(s_q[k]);
					err_n[k] = err_n[k] - $signed(ERR_W'(a_q[dom_q]));
				end
				err_n[k] = err_n[k] + $signed(ERR_W'(a_q[k]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			op_q       <= cmd_beat.command;
			rd_index_q <= cmd_beat.read_index;
			dom_q      <= dom_l;
			for (int k = 0; k < 3; k++) begin
				p_q[k]   <= beg_l[k];
				fin_q[k] <= fin_l[k];
				a_q[k]   <= a_l[k];
				s_q[k]   <= s_l[k];
				err_q[k] <= err_l[k];
			end
		end else if (dcmd.advance) begin
			for (int k = 0; k < 3; k++) begin
				p_q[k]   <= p_n[k];
				err_q[k] <= err_n[k];
			end
		end
	end

	assign pt_idx = IDX_W'(IDX_W'(p_q[2]) * IDX_W'(CUBE_SIZE) + IDX_W'(p_q[0]));
	assign raddr  = dcmd.rd_index ? rd_index_q : pt_idx;
	assign wdata  = (valid_q[pt_idx] ? rdata : 8'd0) | (8'd1 << p_q[1][2:0]);

	vlr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (dcmd.wr),
		.waddr (pt_idx),
		.wdata (wdata),
		.re    (dcmd.rd_point || dcmd.rd_index),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dcmd.clear) begin
				valid_q <= '0;
			end else if (dcmd.wr) begin
				valid_q[pt_idx] <= 1'b1;
			end
			if (dcmd.load) begin
				count_q <= '0;
			end else if (dcmd.wr) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (dcmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.finish) begin
			out_q.read_data     <= (op_q == CMD_READ && valid_q[rd_index_q]) ? rdata : 8'd0;
			out_q.plotted_count <= (op_q == CMD_DRAW) ? count_q : '0;
		end
	end

	assign stat.in_range = (p_q[0] < COORD_W'(CUBE_SIZE)) && (p_q[1] < COORD_W'(CUBE_SIZE))
		&& (p_q[2] < COORD_W'(CUBE_SIZE));
	assign stat.at_end   = (p_q[dom_q] == fin_q[dom_q]);
	assign stat.out_free = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp_beat  = out_q;

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.finish |=> out_valid_q)
		else $error("result beat lost after finish");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(256))
		else $error("plotted count out of range");

endmodule

### rtl/core/voxel_line_rasterizer.sv
// Top level of the voxel line rasterizer: controller plus datapath.
// Depends on vlr_pkg, vlr_ctrl, vlr_datapath (which holds vlr_ram).
//
//  channel | signals                          | beat type
//  cmd     | cmd_valid, cmd_stall, cmd_beat   | cmd_beat_t
//  rsp     | rsp_valid, rsp_stall, rsp_beat   | rsp_beat_t
//
// A draw visits each point of the dominant axis in S_STEP and adds an S_WRITE step per
// plotted voxel for the read-modify-write on the frame store, which has one read port and
// one write port. A read passes through S_RDREQ to S_DONE; a clear or an unused command
// goes straight to S_DONE. One command is in work at a time.
// Reset clears the frame store at once through its per-byte valid bits.
// A stalled result holds in the output register; the next command is taken
// while it waits.
module voxel_line_rasterizer
	import vlr_pkg::*;
#(
	parameter int CUBE_SIZE = CUBE_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_beat_t cmd_beat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp_beat
);

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	vlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd_beat.command),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.dcmd      (dcmd)
	);

	vlr_datapath #(
		.CUBE_SIZE (CUBE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_beat  (cmd_beat),
		.dcmd      (dcmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat)
	);

endmodule

### dv/voxel_line_rasterizer_tb.sv
// Self-checking testbench for voxel_line_rasterizer: directed table then random command beats,
// every response beat checked in order against a fixed row value or a behavioral 3D line stepper over a voxel mirror.
// Depends on vlr_pkg and the voxel_line_rasterizer RTL.
module voxel_line_rasterizer_tb;
	import vlr_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int EDGE_N         = CUBE_SIZE_DEF;
	localparam int STALL_PCT      = 18;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 3000;
	localparam int QUIET_LO       = 600;
	localparam int QUIET_HI       = 900;
	localparam int RANDOM_BEATS   = 1526;
	localparam int DRAIN_CYCLES   = 600;
	localparam int WATCHDOG_LIMIT = 12000;

	typedef struct {
		cmd_beat_t beat;
		bit        fixed;
		rsp_beat_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_beat_t cmd_beat;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_beat_t rsp_beat;

	logic [7:0] voxel_mirror [STORE_DEPTH];
	rsp_beat_t  pending_rsp [$];
	stim_row_t  stim_rows [$];
	cmd_beat_t  last_line;
	int         mismatches = 0;
	int         beats_sent = 0;

	voxel_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_beat  (cmd_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic rsp_beat_t rasterize(cmd_beat_t b);
		int        beg [3];
		int        fin [3];
		int        p [3];
		int        a [3];
		int        s [3];
		int        e [3];
		int        oth [2];
		int        dom;
		int        o;
		bit        done;
		rsp_beat_t r;
		r = '0;
		case (b.command)
		CMD_DRAW: begin
			beg = '{int'(b.x_start), int'(b.y_start), int'(b.z_start)};
			fin = '{int'(b.x_end), int'(b.y_end), int'(b.z_end)};
			for (int k = 0; k < 3; k++) begin
				a[k] = (fin[k] >= beg[k]) ? 2 * (fin[k] - beg[k]) : 2 * (beg[k] - fin[k]);
				s[k] = (fin[k] > beg[k]) ? 1 : ((fin[k] < beg[k]) ? -1 : 0);
				p[k] = beg[k];
			end
			if (a[0] >= a[1] && a[0] >= a[2])
				dom = 0;
			else if (a[1] >= a[2])
				dom = 1;
			else
				dom = 2;
			oth[0] = (dom == 0) ? 1 : 0;
			oth[1] = (dom == 2) ? 1 : 2;
			for (int k = 0; k < 2; k++)
				e[oth[k]] = a[oth[k]] - a[dom] / 2;
			done = 1'b0;
			while (!done) begin
				if (p[0] >= 0 && p[1] >= 0 && p[2] >= 0 &&
				    p[0] < EDGE_N && p[1] < EDGE_N && p[2] < EDGE_N) begin
					voxel_mirror[(p[2] * EDGE_N + p[0]) & (STORE_DEPTH - 1)][p[1] & 7] = 1'b1;
					r.plotted_count = r.plotted_count + 1'b1;
				end
				if (p[dom] == fin[dom]) begin
					done = 1'b1;
				end else begin
					for (int k = 0; k < 2; k++) begin
						o = oth[k];
						if (e[o] >= 0) begin
							p[o] += s[o];
							e[o] -= a[dom];
						end
					end
					p[dom] += s[dom];
					for (int k = 0; k < 2; k++)
						e[oth[k]] += a[oth[k]];
				end
			end
		end
		CMD_READ: begin
			r.read_data = voxel_mirror[b.read_index];
		end
		CMD_CLEAR: begin
			foreach (voxel_mirror[i])
				voxel_mirror[i] = '0;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	function automatic cmd_beat_t noise_beat();
		logic [$bits(cmd_beat_t)-1:0] raw;
		raw = $bits(cmd_beat_t)'({$urandom, $urandom});
		return raw;
	endfunction

	function automatic cmd_beat_t line_beat(int xs, int ys, int zs, int xe, int ye, int ze);
		cmd_beat_t b;
		b = noise_beat();
		b.command = CMD_DRAW;
		b.x_start = COORD_W'(xs);
		b.y_start = COORD_W'(ys);
		b.z_start = COORD_W'(zs);
		b.x_end   = COORD_W'(xe);
		b.y_end   = COORD_W'(ye);
		b.z_end   = COORD_W'(ze);
		return b;
	endfunction

	function automatic cmd_beat_t plain_beat(logic [1:0] cmd, int idx);
		cmd_beat_t b;
		b = noise_beat();
		b.command    = cmd;
		b.read_index = IDX_W'(idx);
		return b;
	endfunction

	function automatic void add_row(cmd_beat_t b, bit fixed = 1'b0, logic [7:0] rd = '0,
	                                logic [COUNT_W-1:0] cnt = '0);
		stim_row_t row;
		row.beat                = b;
		row.fixed               = fixed;
		row.want.read_data      = rd;
		row.want.plotted_count  = cnt;
		stim_rows.push_back(row);
	endfunction

	function automatic cmd_beat_t random_beat();
		cmd_beat_t b;
		int        pick;
		int        mode;
		b = noise_beat();
		pick = $urandom_range(99);
		if (pick < 55) begin
			b.command = CMD_DRAW;
			mode = $urandom_range(9);
			if (mode <= 6) begin
				b = line_beat($urandom_range(9), $urandom_range(9), $urandom_range(9),
				              $urandom_range(9), $urandom_range(9), $urandom_range(9));
			end else if (mode == 7) begin
				b.x_start = COORD_W'($urandom_range(9));
				b.y_start = COORD_W'($urandom_range(9));
				b.z_start = COORD_W'($urandom_range(9));
			end else if (mode == 8) begin
				b.x_end = COORD_W'($urandom_range(9));
				b.y_end = COORD_W'($urandom_range(9));
				b.z_end = COORD_W'($urandom_range(9));
			end
			last_line = b;
		end else if (pick < 92) begin
			b.command = CMD_READ;
			mode = $urandom_range(9);
			if (mode < 3)
				b.read_index = {last_line.z_start[2:0], last_line.x_start[2:0]};
			else if (mode < 6)
				b.read_index = {last_line.z_end[2:0], last_line.x_end[2:0]};
		end else if (pick < 96) begin
			b.command = CMD_CLEAR;
		end else begin
			b.command = CMD_NOP;
		end
		return b;
	endfunction

	task automatic send_cmd(cmd_beat_t b, bit fixed, rsp_beat_t want);
		rsp_beat_t predicted;
		while (!(beats_sent >= QUIET_LO && beats_sent < QUIET_HI) &&
		       $urandom_range(99) < STALL_PCT) begin
			cmd_valid <= 1'b0;
			cmd_beat  <= noise_beat();
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_beat  <= b;
		@(posedge clk);
		while (cmd_stall !== 1'b0)
			@(posedge clk);
		predicted = rasterize(b);
		pending_rsp.push_back(fixed ? want : predicted);
		beats_sent++;
	endtask

	initial begin
		rsp_beat_t want;
		int        taken;
		int        hold;
		taken = 0;
		hold = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("unexpected response beat: read_data %0d plotted_count %0d",
					       rsp_beat.read_data, rsp_beat.plotted_count);
					mismatches++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp_beat.read_data !== want.read_data) begin
						$error("read_data: expected %0d, got %0d",
						       want.read_data, rsp_beat.read_data);
						mismatches++;
					end
					if (rsp_beat.plotted_count !== want.plotted_count) begin
						$error("plotted_count: expected %0d, got %0d",
						       want.plotted_count, rsp_beat.plotted_count);
						mismatches++;
					end
				end
				taken++;
				if (taken == HOLD_AT)
					hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= !(taken >= QUIET_LO && taken < QUIET_HI) &&
				             ($urandom_range(99) < STALL_PCT);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_beat  = '0;
		last_line = '0;
		foreach (voxel_mirror[i])
			voxel_mirror[i] = '0;

		add_row(plain_beat(CMD_READ, 0), 1'b1, 8'h00, 9'd0);
		add_row(plain_beat(CMD_READ, 63), 1'b1, 8'h00, 9'd0);
		add_row(line_beat(0, 0, 0, 0, 0, 0), 1'b1, 8'h00, 9'd1);
		add_row(line_beat(7, 7, 7, 7, 7, 7), 1'b1, 8'h00, 9'd1);
		add_row(line_beat(8, 0, 0, 8, 0, 0), 1'b1, 8'h00, 9'd0);
		add_row(line_beat(255, 255, 255, 255, 255, 255), 1'b1, 8'h00, 9'd0);
		add_row(plain_beat(CMD_READ, 0), 1'b1, 8'h01, 9'd0);
		add_row(plain_beat(CMD_READ, 63), 1'b1, 8'h80, 9'd0);
		add_row(line_beat(0, 0, 0, 7, 3, 2));
		add_row(line_beat(1, 0, 6, 2, 7, 3));
		add_row(line_beat(7, 7, 0, 0, 5, 7));
		add_row(line_beat(0, 0, 0, 7, 7, 0), 1'b1, 8'h00, 9'd8);
		add_row(line_beat(3, 0, 0, 3, 7, 7));
		add_row(line_beat(7, 7, 7, 0, 0, 0), 1'b1, 8'h00, 9'd8);
		add_row(line_beat(255, 0, 0, 0, 0, 0), 1'b1, 8'h00, 9'd8);
		add_row(line_beat(0, 255, 0, 0, 0, 255));
		add_row(line_beat(0, 0, 0, 255, 255, 255), 1'b1, 8'h00, 9'd8);
		add_row(line_beat(255, 255, 255, 0, 0, 0), 1'b1, 8'h00, 9'd8);
		add_row(line_beat(20, 20, 20, 30, 40, 50), 1'b1, 8'h00, 9'd0);
		add_row(plain_beat(CMD_READ, 8 * 3 + 1));
		add_row(plain_beat(CMD_NOP, 63), 1'b1, 8'h00, 9'd0);
		add_row(plain_beat(CMD_CLEAR, 0), 1'b1, 8'h00, 9'd0);
		add_row(plain_beat(CMD_READ, 0), 1'b1, 8'h00, 9'd0);
		add_row(plain_beat(CMD_READ, 63), 1'b1, 8'h00, 9'd0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i])
			send_cmd(stim_rows[i].beat, stim_rows[i].fixed, stim_rows[i].want);
		repeat (RANDOM_BEATS)
			send_cmd(random_beat(), 1'b0, '0);
		cmd_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/core/vlr_pkg.sv
rtl/core/vlr_ram.sv
rtl/core/vlr_ctrl.sv
rtl/core/vlr_datapath.sv
rtl/core/voxel_line_rasterizer.sv
dv/voxel_line_rasterizer_tb.sv
